>>> rtl/core/rsch_pkg.sv
// Shared types, widths, codes and helper functions for the ray segment clip and hit block.
package rsch_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_W     = COORD_BITS + 1;           // coordinate difference
    localparam int PROD_W     = 2 * DIFF_W;               // product of two differences
    localparam int TURN_W     = PROD_W + 1;               // orientation value
    localparam int CW         = 2 * COORD_BITS + 2;       // line constant c
    localparam int DET_W      = 2 * DIFF_W + 1;           // determinant
    localparam int NPROD_W    = DIFF_W + CW;              // numerator partial product
    localparam int NUM_W      = NPROD_W + 1;              // numerator
    localparam int DSUM_W     = PROD_W + 1;               // squared distance
    localparam int CNT_W      = $clog2(NUM_W);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_WALL = 1'b1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]     t_diff;

    typedef struct packed {
        logic   operation;
        t_coord first_x;
        t_coord first_y;
        t_coord second_x;
        t_coord second_y;
        logic   is_body;
        logic   last_wall;
    } t_in;

    typedef struct packed {
        t_coord clip_x;
        t_coord clip_y;
        logic   body_hit;
    } t_out;

    typedef enum logic [1:0] {
        TURN_COL,
        TURN_POS,
        TURN_NEG
    } t_turn;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_PROD,
        ST_TURN,
        ST_COEF,
        ST_CSUM,
        ST_NPROD,
        ST_NSUM,
        ST_DSTART,
        ST_DIV,
        ST_U,
        ST_SQ,
        ST_CMP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic ld_line;
        logic cap_wall;
        logic st_diff;
        logic st_prod;
        logic st_coef;
        logic st_csum;
        logic st_nprod;
        logic st_nsum;
        logic div_start;
        logic st_quot;
        logic st_u;
        logic st_sq;
        logic st_cmp;
        logic set_struck;
        logic ld_out;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic is_body;
        logic det_zero;
        logic div_done;
    } t_stat;

    function automatic t_diff f_dif(input t_coord a, input t_coord b);
        f_dif = DIFF_W'(a) - DIFF_W'(b);
    endfunction

    function automatic t_turn f_turn(input logic signed [TURN_W-1:0] v);
        if (v == '0) begin
            f_turn = TURN_COL;
        end else if (v[TURN_W-1]) begin
            f_turn = TURN_NEG;
        end else begin
            f_turn = TURN_POS;
        end
    endfunction

    // q lies in the box spanned by p and r
    function automatic logic f_within(input t_coord px, input t_coord py, input t_coord qx,
                                      input t_coord qy, input t_coord rx, input t_coord ry);
        t_coord hx, lx, hy, ly;
        hx = (px > rx) ? px : rx;
        lx = (px < rx) ? px : rx;
        hy = (py > ry) ? py : ry;
        ly = (py < ry) ? py : ry;
        f_within = (qx <= hx) && (qx >= lx) && (qy <= hy) && (qy >= ly);
    endfunction

    // clamp a quotient magnitude with sign to the coordinate range
    function automatic t_coord f_sat(input logic [NUM_W-1:0] mag, input logic neg);
        logic [NUM_W-1:0] pos_lim, neg_lim;
        t_coord low;
        pos_lim = (NUM_W'(1) << (COORD_BITS - 1)) - NUM_W'(1);
        neg_lim = NUM_W'(1) << (COORD_BITS - 1);
        low     = mag[COORD_BITS-1:0];
        if (neg) begin
            f_sat = (mag > neg_lim) ? t_coord'(neg_lim[COORD_BITS-1:0]) : -low;
        end else begin
            f_sat = (mag > pos_lim) ? t_coord'(pos_lim[COORD_BITS-1:0]) : low;
        end
    endfunction

endpackage

>>> rtl/core/ray_segment_clip_and_hit_top.sv
// Top level of the ray segment clip and hit block.
//
//   channel | direction | handshake                 | beat
//   --------+-----------+---------------------------+------------------------------
//   in      | into      | i_in_valid / o_in_stall   | t_in: line load or wall
//   out     | out of    | o_out_valid / i_out_stall | t_out: clipped end, body hit
//
// A line load is taken in the idle state and the next beat may follow at once.
// A wall ends after the orientation test when it misses or the line is a body line;
// a vision hit runs the intersection through the shared divider, which produces
// one quotient bit per cycle for both coordinates over 52 steps (parallel lines
// skip the divider).
// Synchronous active-low reset clears the line to a zero-length vision line.
// The result register frees the input side: only a last wall waits for it.
module ray_segment_clip_and_hit_top import rsch_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);
    t_cmd  cmd;
    t_stat stat;

    // sequence each accepted beat through the datapath
    rsch_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_op     (i_in.operation),
        .i_in_last   (i_in.last_wall),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // hold the line, test the wall, clip the end
    rsch_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_in    (i_in),
        .o_stat  (stat),
        .o_out   (o_out)
    );
endmodule

>>> rtl/core/rsch_div.sv
// Two-lane restoring divider sharing one divisor, one quotient bit per cycle.
module rsch_div import rsch_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [NUM_W-1:0]   i_num_x,
    input  logic [NUM_W-1:0]   i_num_y,
    input  logic [DET_W-1:0]   i_den,
    output logic               o_done,
    output logic [NUM_W-1:0]   o_quot_x,
    output logic [NUM_W-1:0]   o_quot_y
);
    logic [NUM_W-1:0] r_nx, r_ny;
    logic [DET_W:0]   r_rx, r_ry;
    logic [DET_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;
    logic [DET_W:0]   sx, sy, den_ext;
    logic             gx, gy;

    assign den_ext = {1'b0, r_den};
    assign sx      = {r_rx[DET_W-1:0], r_nx[NUM_W-1]};
    assign sy      = {r_ry[DET_W-1:0], r_ny[NUM_W-1]};
    assign gx      = (sx >= den_ext);
    assign gy      = (sy >= den_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    // numerator register fills with quotient bits from the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_nx  <= i_num_x;
            r_ny  <= i_num_y;
            r_rx  <= '0;
            r_ry  <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rx <= gx ? (sx - den_ext) : sx;
            r_ry <= gy ? (sy - den_ext) : sy;
            r_nx <= {r_nx[NUM_W-2:0], gx};
            r_ny <= {r_ny[NUM_W-2:0], gy};
        end
    end

    assign o_done   = r_done;
    assign o_quot_x = r_nx;
    assign o_quot_y = r_ny;
endmodule

>>> rtl/core/rsch_dp.sv
// Datapath: line state, orientation tests, intersection arithmetic and result register.
module rsch_dp import rsch_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    input  t_in   i_in,
    output t_stat o_stat,
    output t_out  o_out
);
    t_coord r_ox, r_oy, r_ex, r_ey;
    logic   r_is_body, r_struck;
    t_coord r_wx1, r_wy1, r_wx2, r_wy2;
    t_diff  r_td [0:3][0:3];
    t_diff  r_b1, r_b2;
    logic signed [PROD_W-1:0]  r_tp [0:3][0:1];
    logic                      r_in [0:3];
    logic signed [PROD_W-1:0]  r_m [0:5];
    logic signed [CW-1:0]      r_c1, r_c2;
    logic signed [DET_W-1:0]   r_det;
    logic signed [NPROD_W-1:0] r_n [0:3];
    logic signed [NUM_W-1:0]   r_nx, r_ny;
    t_coord r_px, r_py;
    t_diff  r_ux, r_uy;
    logic signed [PROD_W-1:0]  r_s [0:3];
    t_out   r_out;

    t_turn            o1, o2, o3, o4;
    logic [NUM_W-1:0] mag_x, mag_y, q_x, q_y;
    logic [DET_W-1:0] mag_d;
    logic             q_done, neg_x, neg_y;
    logic signed [DSUM_W-1:0] d_line, d_cut;

    always_comb begin
        o1 = f_turn(TURN_W'(r_tp[0][0]) - TURN_W'(r_tp[0][1]));
        o2 = f_turn(TURN_W'(r_tp[1][0]) - TURN_W'(r_tp[1][1]));
        o3 = f_turn(TURN_W'(r_tp[2][0]) - TURN_W'(r_tp[2][1]));
        o4 = f_turn(TURN_W'(r_tp[3][0]) - TURN_W'(r_tp[3][1]));
    end

    assign o_stat.hit = ((o1 != o2) && (o3 != o4))
        || ((o1 == TURN_COL) && r_in[0]) || ((o2 == TURN_COL) && r_in[1])
        || ((o3 == TURN_COL) && r_in[2]) || ((o4 == TURN_COL) && r_in[3]);
    assign o_stat.is_body  = r_is_body;
    assign o_stat.det_zero = (r_det == '0);
    assign o_stat.div_done = q_done;

    assign mag_x = r_nx[NUM_W-1] ? NUM_W'(-r_nx) : NUM_W'(r_nx);
    assign mag_y = r_ny[NUM_W-1] ? NUM_W'(-r_ny) : NUM_W'(r_ny);
    assign mag_d = r_det[DET_W-1] ? DET_W'(-r_det) : DET_W'(r_det);
    assign neg_x = r_nx[NUM_W-1] ^ r_det[DET_W-1];
    assign neg_y = r_ny[NUM_W-1] ^ r_det[DET_W-1];

    rsch_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.div_start),
        .i_num_x  (mag_x),
        .i_num_y  (mag_y),
        .i_den    (mag_d),
        .o_done   (q_done),
        .o_quot_x (q_x),
        .o_quot_y (q_y)
    );

    assign d_line = DSUM_W'(r_s[0]) + DSUM_W'(r_s[1]);
    assign d_cut  = DSUM_W'(r_s[2]) + DSUM_W'(r_s[3]);

    // architectural line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ox      <= '0;
            r_oy      <= '0;
            r_ex      <= '0;
            r_ey      <= '0;
            r_is_body <= 1'b0;
            r_struck  <= 1'b0;
        end else begin
            if (i_cmd.ld_line) begin
                r_ox      <= i_in.first_x;
                r_oy      <= i_in.first_y;
                r_ex      <= i_in.second_x;
                r_ey      <= i_in.second_y;
                r_is_body <= i_in.is_body;
                r_struck  <= 1'b0;
            end
            if (i_cmd.set_struck) begin
                r_struck <= 1'b1;
            end
            if (i_cmd.st_cmp && (d_line > d_cut)) begin
                r_ex <= r_px;
                r_ey <= r_py;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_wall) begin
            r_wx1 <= i_in.first_x;
            r_wy1 <= i_in.first_y;
            r_wx2 <= i_in.second_x;
            r_wy2 <= i_in.second_y;
        end
        if (i_cmd.st_diff) begin
            r_td[0][0] <= f_dif(r_ey, r_oy);
            r_td[0][1] <= f_dif(r_wx1, r_ex);
            r_td[0][2] <= f_dif(r_ex, r_ox);
            r_td[0][3] <= f_dif(r_wy1, r_ey);
            r_td[1][0] <= f_dif(r_ey, r_oy);
            r_td[1][1] <= f_dif(r_wx2, r_ex);
            r_td[1][2] <= f_dif(r_ex, r_ox);
            r_td[1][3] <= f_dif(r_wy2, r_ey);
            r_td[2][0] <= f_dif(r_wy2, r_wy1);
            r_td[2][1] <= f_dif(r_ox, r_wx2);
            r_td[2][2] <= f_dif(r_wx2, r_wx1);
            r_td[2][3] <= f_dif(r_oy, r_wy2);
            r_td[3][0] <= f_dif(r_wy2, r_wy1);
            r_td[3][1] <= f_dif(r_ex, r_wx2);
            r_td[3][2] <= f_dif(r_wx2, r_wx1);
            r_td[3][3] <= f_dif(r_ey, r_wy2);
            r_b1       <= f_dif(r_ox, r_ex);
            r_b2       <= f_dif(r_wx1, r_wx2);
        end
        if (i_cmd.st_prod) begin
            for (int k = 0; k < 4; k++) begin
                r_tp[k][0] <= PROD_W'(r_td[k][0]) * PROD_W'(r_td[k][1]);
                r_tp[k][1] <= PROD_W'(r_td[k][2]) * PROD_W'(r_td[k][3]);
            end
            r_in[0] <= f_within(r_ox, r_oy, r_wx1, r_wy1, r_ex, r_ey);
            r_in[1] <= f_within(r_ox, r_oy, r_wx2, r_wy2, r_ex, r_ey);
            r_in[2] <= f_within(r_wx1, r_wy1, r_ox, r_oy, r_wx2, r_wy2);
            r_in[3] <= f_within(r_wx1, r_wy1, r_ex, r_ey, r_wx2, r_wy2);
        end
        // a1 = td[0][0], a2 = td[2][0]
        if (i_cmd.st_coef) begin
            r_m[0] <= PROD_W'(r_td[0][0]) * PROD_W'(r_ox);
            r_m[1] <= PROD_W'(r_b1) * PROD_W'(r_oy);
            r_m[2] <= PROD_W'(r_td[2][0]) * PROD_W'(r_wx1);
            r_m[3] <= PROD_W'(r_b2) * PROD_W'(r_wy1);
            r_m[4] <= PROD_W'(r_td[0][0]) * PROD_W'(r_b2);
            r_m[5] <= PROD_W'(r_td[2][0]) * PROD_W'(r_b1);
        end
        if (i_cmd.st_csum) begin
            r_c1  <= CW'(r_m[0]) + CW'(r_m[1]);
            r_c2  <= CW'(r_m[2]) + CW'(r_m[3]);
            r_det <= DET_W'(r_m[4]) - DET_W'(r_m[5]);
        end
        if (i_cmd.st_nprod) begin
            r_n[0] <= NPROD_W'(r_b2) * NPROD_W'(r_c1);
            r_n[1] <= NPROD_W'(r_b1) * NPROD_W'(r_c2);
            r_n[2] <= NPROD_W'(r_td[0][0]) * NPROD_W'(r_c2);
            r_n[3] <= NPROD_W'(r_td[2][0]) * NPROD_W'(r_c1);
        end
        if (i_cmd.st_nsum) begin
            r_nx <= NUM_W'(r_n[0]) - NUM_W'(r_n[1]);
            r_ny <= NUM_W'(r_n[2]) - NUM_W'(r_n[3]);
        end
        // parallel lines give the point at the origin of the plane
        if (i_cmd.st_quot) begin
            r_px <= (r_det == '0) ? '0 : f_sat(q_x, neg_x);
            r_py <= (r_det == '0) ? '0 : f_sat(q_y, neg_y);
        end
        if (i_cmd.st_u) begin
            r_ux <= f_dif(r_px, r_ox);
            r_uy <= f_dif(r_py, r_oy);
        end
        if (i_cmd.st_sq) begin
            r_s[0] <= PROD_W'(r_td[0][2]) * PROD_W'(r_td[0][2]);
            r_s[1] <= PROD_W'(r_td[0][0]) * PROD_W'(r_td[0][0]);
            r_s[2] <= PROD_W'(r_ux) * PROD_W'(r_ux);
            r_s[3] <= PROD_W'(r_uy) * PROD_W'(r_uy);
        end
        if (i_cmd.ld_out) begin
            r_out.clip_x   <= r_ex;
            r_out.clip_y   <= r_ey;
            r_out.body_hit <= r_struck;
        end
    end

    assign o_out = r_out;
endmodule

>>> rtl/core/rsch_ctrl.sv
// Controller: sequences one item through the datapath and owns the handshakes.
module rsch_ctrl import rsch_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_op,
    input  logic  i_in_last,
    input  logic  i_out_stall,
    input  t_stat i_stat,
    output logic  o_in_stall,
    output logic  o_out_valid,
    output t_cmd  o_cmd
);
    t_state r_state, n_state;
    logic   r_last, r_out_valid, out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.cap_wall) begin
                r_last <= i_in_last;
            end
            if (o_cmd.ld_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_op == OP_LOAD) begin
                        o_cmd.ld_line = 1'b1;
                    end else begin
                        o_cmd.cap_wall = 1'b1;
                        n_state        = ST_DIFF;
                    end
                end
            end
            ST_DIFF: begin
                o_cmd.st_diff = 1'b1;
                n_state       = ST_PROD;
            end
            ST_PROD: begin
                o_cmd.st_prod = 1'b1;
                n_state       = ST_TURN;
            end
            ST_TURN: begin
                if (!i_stat.hit) begin
                    n_state = ST_DONE;
                end else if (i_stat.is_body) begin
                    o_cmd.set_struck = 1'b1;
                    n_state          = ST_DONE;
                end else begin
                    n_state = ST_COEF;
                end
            end
            ST_COEF: begin
                o_cmd.st_coef = 1'b1;
                n_state       = ST_CSUM;
            end
            ST_CSUM: begin
                o_cmd.st_csum = 1'b1;
                n_state       = ST_NPROD;
            end
            ST_NPROD: begin
                o_cmd.st_nprod = 1'b1;
                n_state        = ST_NSUM;
            end
            ST_NSUM: begin
                o_cmd.st_nsum = 1'b1;
                n_state       = ST_DSTART;
            end
            ST_DSTART: begin
                if (i_stat.det_zero) begin
                    o_cmd.st_quot = 1'b1;
                    n_state       = ST_U;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.st_quot = 1'b1;
                    n_state       = ST_U;
                end
            end
            ST_U: begin
                o_cmd.st_u = 1'b1;
                n_state    = ST_SQ;
            end
            ST_SQ: begin
                o_cmd.st_sq = 1'b1;
                n_state     = ST_CMP;
            end
            ST_CMP: begin
                o_cmd.st_cmp = 1'b1;
                n_state      = ST_DONE;
            end
            ST_DONE: begin
                // a last wall holds until the result register can take the beat
                if (!r_last) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    o_cmd.ld_out = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
endmodule

>>> rtl/core/rsch_chk.sv
// Port-level checker for the ray segment clip and hit block, with its bind.
module rsch_chk import rsch_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input t_in  i_in,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out
);
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result beat valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("stalled result beat dropped");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out))
        else $error("stalled result beat changed");

    a_wall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in.operation == OP_WALL) |=> o_in_stall)
        else $error("wall beat did not occupy the block");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in.operation == OP_LOAD) |=> !o_in_stall)
        else $error("line load stalled the next beat");
endmodule

bind ray_segment_clip_and_hit_top rsch_chk u_rsch_chk (.*);
